/* hw/rtl/wcf_pkg.sv */
// Shared constants, types and helpers of the window correlation filter.
package wcf_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int WIN         = KERNEL_SIZE * KERNEL_SIZE;
  localparam int MAX_WIDTH   = 1024;
  localparam int COEF_BITS   = 16;
  localparam int NCH         = 3;
  localparam int PIX_BITS    = 8;
  localparam int PIXEL_W     = NCH * PIX_BITS;

  localparam int SLOTS   = 4;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = COL_W + 1;
  localparam int ROW_W   = 16;
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int STORE_DEPTH = SLOTS * MAX_WIDTH;

  localparam int PROD_W = PIX_BITS + 1 + COEF_BITS;
  localparam int GRP_W  = PROD_W + 2;
  localparam int SUM_W  = GRP_W + 3;
  localparam int OUT_W  = 28;
  localparam int PEND_W = $clog2((KERNEL_SIZE - 1) * MAX_WIDTH + KERNEL_SIZE + 1);

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int ANC_W     = 4;
  localparam int OFF_W     = 16;
  localparam int FILL_W    = 9;
  localparam int IDX_W     = 2;

  localparam int OUT_QUEUE_DEPTH = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_CELL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_FILL   = 3'd7;

  // opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // reset values
  localparam logic [CFG_W-1:0]  RST_KERNEL_TOP    = 48'd0;
  localparam logic [CFG_W-1:0]  RST_KERNEL_MIDDLE = 48'd256;
  localparam logic [CFG_W-1:0]  RST_KERNEL_BOTTOM = 48'd0;
  localparam logic [WID_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT  = 16'd480;
  localparam logic [ANC_W-1:0]  RST_ANCHOR_CELL   = 4'd4;
  localparam logic [OFF_W-1:0]  RST_OFFSET_VALUE  = 16'd0;
  localparam logic [FILL_W-1:0] RST_BORDER_FILL   = 9'd0;
  localparam logic [FILL_W-1:0] FILL_REPLICATE    = 9'd256;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [NCH-1:0] chan_prod_t;
  typedef chan_prod_t [WIN-1:0] win_prod_t;
  typedef logic signed [OUT_W-1:0] osum_t;
  typedef osum_t [NCH-1:0] chan_sum_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  // output position and frame geometry seen by every lane
  typedef struct packed {
    logic [ROW_W-1:0]    orow;
    logic [COL_W-1:0]    ocol;
    logic [SLOT_W-1:0]   oslot;
    logic [IDX_W-1:0]    ay;
    logic [IDX_W-1:0]    ax;
    logic [ROW_W-1:0]    h;
    logic [WID_W-1:0]    w;
    logic                repl;
    logic [PIX_BITS-1:0] fill;
  } geom_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    pixel_t            data;
  } wr_t;

  function automatic logic [IDX_W-1:0] anchor_row(input logic [ANC_W-1:0] a);
    logic [IDX_W-1:0] r;
    case (a)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] anchor_col(input logic [ANC_W-1:0] a);
    logic [IDX_W-1:0] c;
    case (a)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/window_correlation_filter.sv */
// Top level: 3x3 windowed correlation filter with border handling over a pixel stream.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | opcode, chan_blue, chan_green, chan_red
//  out_    | output    | out_valid/out_ready  | sum_blue/green/red, row, col, frame_last
//  cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_wdata (48 bits)
//
//  One request per cycle while in_ready is high. A result passes through the gather/RAM
//  read, multiply, group add and final add into the output queue.
//  in_ready drops only when OUT_QUEUE_DEPTH results are in flight or queued.
//  Reset (rst_n low at a clock edge) clears counters, queue and config to defaults;
//  line store contents are not cleared.
//
// Nine lanes, one per window cell, each hold a full copy of the four-row line
// store so every cell reads its pixel in the same cycle. A pixel written in the
// same cycle that a lane reads is forwarded around the RAM. The merge stage sums
// lanes row by row, adds the offset and queues the result.
module window_correlation_filter #(
  parameter int OUT_QUEUE_DEPTH = wcf_pkg::OUT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [7:0]                        in_chan_blue,
  input  logic [7:0]                        in_chan_green,
  input  logic [7:0]                        in_chan_red,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wcf_pkg::OUT_W-1:0]  out_sum_blue,
  output logic signed [wcf_pkg::OUT_W-1:0]  out_sum_green,
  output logic signed [wcf_pkg::OUT_W-1:0]  out_sum_red,
  output logic [15:0]                       out_row,
  output logic [9:0]                        out_col,
  output logic                              out_frame_last,
  // configuration
  input  logic                              cfg_we,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcf_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int ROW_W  = wcf_pkg::ROW_W;
  localparam int COL_W  = wcf_pkg::COL_W;
  localparam int WID_W  = wcf_pkg::WID_W;
  localparam int SLOT_W = wcf_pkg::SLOT_W;
  localparam int PEND_W = wcf_pkg::PEND_W;
  localparam int KS     = wcf_pkg::KERNEL_SIZE;
  localparam int CB     = wcf_pkg::COEF_BITS;

  // configuration registers
  logic [wcf_pkg::CFG_W-1:0]  krow_r [KS];
  logic [WID_W-1:0]           width_r;
  logic [ROW_W-1:0]           height_r;
  logic [wcf_pkg::ANC_W-1:0]  anchor_r;
  logic [wcf_pkg::OFF_W-1:0]  offset_r;
  logic [wcf_pkg::FILL_W-1:0] fill_r;

  // stream state
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              s1_valid_r;
  wcf_pkg::meta_t    s1_meta_r;

  // effective settings
  logic [WID_W-1:0]          w_eff;
  logic [ROW_W-1:0]          h_eff;
  logic [wcf_pkg::ANC_W-1:0] a_eff;
  logic [wcf_pkg::IDX_W-1:0] ay, ax;
  logic [PEND_W-1:0]         lag;

  logic              accept, is_pix, emit, credit_ok;
  logic              in_col_wrap, out_col_wrap, in_row_wrap, out_row_wrap, frame_last;
  wcf_pkg::geom_t    geom;
  wcf_pkg::wr_t      wr;
  wcf_pkg::win_prod_t prod;
  wcf_pkg::meta_t    q_meta;
  wcf_pkg::chan_sum_t q_sum;

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r[0] <= wcf_pkg::RST_KERNEL_TOP;
      krow_r[1] <= wcf_pkg::RST_KERNEL_MIDDLE;
      krow_r[2] <= wcf_pkg::RST_KERNEL_BOTTOM;
      width_r   <= wcf_pkg::RST_IMAGE_WIDTH;
      height_r  <= wcf_pkg::RST_IMAGE_HEIGHT;
      anchor_r  <= wcf_pkg::RST_ANCHOR_CELL;
      offset_r  <= wcf_pkg::RST_OFFSET_VALUE;
      fill_r    <= wcf_pkg::RST_BORDER_FILL;
    end else if (cfg_we) begin
      case (cfg_index)
        wcf_pkg::REG_KERNEL_TOP:    krow_r[0] <= cfg_wdata;
        wcf_pkg::REG_KERNEL_MIDDLE: krow_r[1] <= cfg_wdata;
        wcf_pkg::REG_KERNEL_BOTTOM: krow_r[2] <= cfg_wdata;
        wcf_pkg::REG_IMAGE_WIDTH:   width_r   <= cfg_wdata[WID_W-1:0];
        wcf_pkg::REG_IMAGE_HEIGHT:  height_r  <= cfg_wdata[ROW_W-1:0];
        wcf_pkg::REG_ANCHOR_CELL:   anchor_r  <= cfg_wdata[wcf_pkg::ANC_W-1:0];
        wcf_pkg::REG_OFFSET_VALUE:  offset_r  <= cfg_wdata[wcf_pkg::OFF_W-1:0];
        wcf_pkg::REG_BORDER_FILL:   fill_r    <= cfg_wdata[wcf_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // width 0 acts as 1 and is capped at the line length; height 0 acts as 1;
  // anchor codes past the last cell act as the last cell
  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(wcf_pkg::MAX_WIDTH)) begin
      w_eff = WID_W'(wcf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
    a_eff = (anchor_r > wcf_pkg::ANC_W'(wcf_pkg::WIN - 1)) ?
            wcf_pkg::ANC_W'(wcf_pkg::WIN - 1) : anchor_r;
    ay    = wcf_pkg::anchor_row(a_eff);
    ax    = wcf_pkg::anchor_col(a_eff);
    // outputs trail inputs by this many pixels
    lag   = PEND_W'(w_eff) * PEND_W'(wcf_pkg::IDX_W'(KS - 1) - ay)
          + PEND_W'(wcf_pkg::IDX_W'(KS - 1) - ax);
  end

  // ---- request decode ----
  assign in_ready = credit_ok;
  assign accept   = in_valid && in_ready;
  assign is_pix   = (in_opcode == wcf_pkg::OP_PIXEL);

  always_comb begin
    if (!accept) begin
      emit = 1'b0;
    end else if (is_pix) begin
      emit = (pend_r >= lag);
    end else begin
      // flush drains only once the input side has closed its frame
      emit = (in_row_r == '0) && (in_col_r == '0) && (pend_r != '0);
    end
  end

  always_comb begin
    in_col_wrap  = (WID_W'(in_col_r) + WID_W'(1)) >= w_eff;
    in_row_wrap  = ({1'b0, in_row_r} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
    out_col_wrap = (WID_W'(out_col_r) + WID_W'(1)) >= w_eff;
    out_row_wrap = ({1'b0, out_row_r} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
    frame_last   = (out_row_r == h_eff - ROW_W'(1)) &&
                   (WID_W'(out_col_r) == w_eff - WID_W'(1));

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    in_slot_nxt = in_slot_r;
    if (accept && is_pix) begin
      if (in_col_wrap) begin
        in_col_nxt  = '0;
        in_slot_nxt = in_slot_r + 1'b1;
        in_row_nxt  = in_row_wrap ? '0 : in_row_r + 1'b1;
      end else begin
        in_col_nxt  = in_col_r + 1'b1;
      end
    end

    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_slot_nxt = out_slot_r;
    if (emit) begin
      if (out_col_wrap) begin
        out_col_nxt  = '0;
        out_slot_nxt = out_slot_r + 1'b1;
        out_row_nxt  = out_row_wrap ? '0 : out_row_r + 1'b1;
      end else begin
        out_col_nxt  = out_col_r + 1'b1;
      end
    end

    pend_nxt = pend_r + PEND_W'(accept && is_pix) - PEND_W'(emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
      pend_r     <= pend_nxt;
      s1_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r.row  <= out_row_r;
    s1_meta_r.col  <= out_col_r;
    s1_meta_r.last <= frame_last;
  end

  // ---- lanes ----
  always_comb begin
    geom.orow  = out_row_r;
    geom.ocol  = out_col_r;
    geom.oslot = out_slot_r;
    geom.ay    = ay;
    geom.ax    = ax;
    geom.h     = h_eff;
    geom.w     = w_eff;
    geom.repl  = (fill_r >= wcf_pkg::FILL_REPLICATE);
    geom.fill  = fill_r[wcf_pkg::PIX_BITS-1:0];
    wr.we      = accept && is_pix;
    wr.addr    = {in_slot_r, in_col_r};
    wr.data    = {in_chan_red, in_chan_green, in_chan_blue};
  end

  for (genvar k = 0; k < KS; k++) begin : g_row
    for (genvar l = 0; l < KS; l++) begin : g_col
      wcf_lane #(
        .LANE_ROW(k),
        .LANE_COL(l)
      ) u_lane (
        .clk (clk),
        .geom(geom),
        .wr  (wr),
        .coef($signed(krow_r[k][l*CB +: CB])),
        .prod(prod[k*KS+l])
      );
    end
  end

  // ---- merge and output queue ----
  wcf_merge #(
    .DEPTH(OUT_QUEUE_DEPTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_meta  (s1_meta_r),
    .prod     (prod),
    .offset   ($signed(offset_r)),
    .emit_acc (emit),
    .credit_ok(credit_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_meta (q_meta),
    .out_sum  (q_sum)
  );

  assign out_sum_blue   = q_sum[0];
  assign out_sum_green  = q_sum[1];
  assign out_sum_red    = q_sum[2];
  assign out_row        = q_meta.row;
  assign out_col        = q_meta.col;
  assign out_frame_last = q_meta.last;

  a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pix) |=> pend_r == $past(pend_r) - PEND_W'($past(emit)))
    else $error("flush request changed the pending count wrongly");

  a_ready_credit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> s1_valid_r)
    else $error("emitted request lost before merge");

  a_slot_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_col_wrap) |=> out_slot_r == $past(out_slot_r) + 1'b1)
    else $error("output row slot did not advance at row end");

endmodule

/* hw/rtl/wcf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/wcf_lane.sv */
// One window cell: border/clamp addressing, own line store copy, three-channel multiply.
module wcf_lane #(
  parameter int LANE_ROW = 0,
  parameter int LANE_COL = 0
) (
  input  logic                               clk,
  input  wcf_pkg::geom_t                     geom,
  input  wcf_pkg::wr_t                       wr,
  input  logic signed [wcf_pkg::COEF_BITS-1:0] coef,
  output wcf_pkg::chan_prod_t                prod
);

  localparam int RW = wcf_pkg::ROW_W + 2;
  localparam int CW = wcf_pkg::COL_W + 3;
  localparam logic signed [RW-1:0] LR = RW'(LANE_ROW);
  localparam logic signed [CW-1:0] LC = CW'(LANE_COL);

  logic signed [RW-1:0] rr, rr_c, h_s, orow_s, drow;
  logic signed [CW-1:0] cc, cc_c, w_s;
  logic                 outside;
  logic [wcf_pkg::SLOT_W-1:0] slot;
  logic [wcf_pkg::ADDR_W-1:0] raddr;
  logic                 fill_sel, byp;
  logic                 fill_r, byp_r;
  wcf_pkg::pixel_t      wdata_r, fillpix_r, rdata, px;
  wcf_pkg::chan_prod_t  prod_r;

  always_comb begin
    orow_s = $signed({2'b00, geom.orow});
    h_s    = $signed({2'b00, geom.h});
    w_s    = $signed({2'b00, geom.w});
    rr     = orow_s + LR - $signed({{(RW-wcf_pkg::IDX_W){1'b0}}, geom.ay});
    cc     = $signed({3'b000, geom.ocol}) + LC
             - $signed({{(CW-wcf_pkg::IDX_W){1'b0}}, geom.ax});
    outside = (rr < 0) || (rr >= h_s) || (cc < 0) || (cc >= w_s);
    if (rr < 0) begin
      rr_c = '0;
    end else if (rr >= h_s) begin
      rr_c = h_s - RW'(1);
    end else begin
      rr_c = rr;
    end
    if (cc < 0) begin
      cc_c = '0;
    end else if (cc >= w_s) begin
      cc_c = w_s - CW'(1);
    end else begin
      cc_c = cc;
    end
    drow     = rr_c - orow_s;
    slot     = geom.oslot + drow[wcf_pkg::SLOT_W-1:0];
    raddr    = {slot, cc_c[wcf_pkg::COL_W-1:0]};
    fill_sel = outside && !geom.repl;
    // same-cycle write to the entry being read
    byp      = wr.we && (wr.addr == raddr);
  end

  wcf_ram #(
    .WIDTH(wcf_pkg::PIXEL_W),
    .DEPTH(wcf_pkg::STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    fill_r    <= fill_sel;
    byp_r     <= byp;
    wdata_r   <= wr.data;
    fillpix_r <= {wcf_pkg::NCH{geom.fill}};
  end

  always_comb begin
    if (fill_r) begin
      px = fillpix_r;
    end else if (byp_r) begin
      px = wdata_r;
    end else begin
      px = rdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < wcf_pkg::NCH; c++) begin
      prod_r[c] <= $signed({1'b0, px[c*wcf_pkg::PIX_BITS +: wcf_pkg::PIX_BITS]}) * coef;
    end
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/wcf_merge.sv */
// Merging adder tree, offset add and output queue with credit tracking.
module wcf_merge #(
  parameter int DEPTH = wcf_pkg::OUT_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             s1_valid,
  input  wcf_pkg::meta_t                   s1_meta,
  input  wcf_pkg::win_prod_t               prod,
  input  logic signed [wcf_pkg::OFF_W-1:0] offset,
  input  logic                             emit_acc,
  output logic                             credit_ok,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wcf_pkg::meta_t                   out_meta,
  output wcf_pkg::chan_sum_t               out_sum
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int GROUPS = wcf_pkg::KERNEL_SIZE;

  logic                         s2_valid_r, s3_valid_r;
  wcf_pkg::meta_t               s2_meta_r, s3_meta_r;
  logic signed [wcf_pkg::GRP_W-1:0] grp_r [GROUPS][wcf_pkg::NCH];
  logic signed [wcf_pkg::SUM_W-1:0] total [wcf_pkg::NCH];
  wcf_pkg::chan_sum_t           s3_sum;

  wcf_pkg::chan_sum_t           q_sum_r  [DEPTH];
  wcf_pkg::meta_t               q_meta_r [DEPTH];
  logic [PTR_W-1:0]             wp_r, rp_r;
  logic [CNT_W-1:0]             fcnt_r, occ_r;
  logic                         pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  // three lanes per group, one kernel row each
  always_ff @(posedge clk) begin
    s2_meta_r <= s1_meta;
    s3_meta_r <= s2_meta_r;
    for (int g = 0; g < GROUPS; g++) begin
      for (int c = 0; c < wcf_pkg::NCH; c++) begin
        grp_r[g][c] <= wcf_pkg::GRP_W'($signed(prod[g*GROUPS][c]))
                     + wcf_pkg::GRP_W'($signed(prod[g*GROUPS+1][c]))
                     + wcf_pkg::GRP_W'($signed(prod[g*GROUPS+2][c]));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < wcf_pkg::NCH; c++) begin
      total[c] = wcf_pkg::SUM_W'(grp_r[0][c]) + wcf_pkg::SUM_W'(grp_r[1][c])
               + wcf_pkg::SUM_W'(grp_r[2][c])
               + (wcf_pkg::SUM_W'(offset) <<< 8);
      s3_sum[c] = total[c][wcf_pkg::OUT_W-1:0];
    end
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (fcnt_r != '0);
  assign out_meta  = q_meta_r[rp_r];
  assign out_sum   = q_sum_r[rp_r];
  assign credit_ok = (occ_r < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      q_sum_r[wp_r]  <= s3_sum;
      q_meta_r[wp_r] <= s3_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
      occ_r  <= '0;
    end else begin
      if (s3_valid_r) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      fcnt_r <= fcnt_r + CNT_W'(s3_valid_r) - CNT_W'(pop);
      occ_r  <= occ_r + CNT_W'(emit_acc) - CNT_W'(pop);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("result occupancy above queue depth");

  a_fill_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= occ_r)
    else $error("queue holds more results than were requested");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (fcnt_r < CNT_W'(DEPTH)) || pop)
    else $error("queue written while full");

  a_emit_credit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_acc |=> occ_r != '0)
    else $error("accepted result not counted");

endmodule
